@@ src/swrc_pkg.sv @@
// Package for the sliding window range convergence block.
// Holds the transaction payload types, field widths, register indexes and reset values.
// No dependencies; the top level imports it.
package swrc_pkg;

    localparam int DATA_W     = 32;
    localparam int WLEN_W     = 11;
    localparam int THR_W      = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_THRESHOLD = 2'd1;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd1024;
    localparam logic [THR_W-1:0]  THR_RESET  = 31'd66;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] window_max;
        logic signed [DATA_W-1:0] window_min;
        logic                     window_full;
        logic                     converged;
    } t_out_item;

endpackage

@@ src/swrc_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transaction.
// The payload type is a parameter; the block uses the types of swrc_pkg.
interface swrc_stream_if #(
    parameter type T = logic [31:0]
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/swrc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; the sample ring of the top level is one instance.
module swrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/sliding_window_range_convergence.sv @@
// Sliding window range convergence: window max/min over a sample ring, converged flag.
// Depends on swrc_pkg, swrc_stream_if and swrc_ram.
//
//   channel    direction  payload                                   handshake
//   i_sample   in         sample_value                              valid/ready
//   o_result   out        window_max, window_min, full, converged   valid/ready
//   i_cfg_*    in         register index, write data                write enable only
//
// While both window extremes stay inside the window, an accepted item goes straight to the emit
// state, where its result is loaded once the result register is free. On the first item, when
// one extreme expires or when the window length changed, the ring is first read back one entry
// per cycle over the older samples of the window, and the item then goes on to the emit state.
// One item is in work at a time; the result register lets the next item enter while it waits,
// and a held result stalls the item behind it in its emit state.
// Reset is synchronous and clears the control state; the ring needs no clearing.
module sliding_window_range_convergence #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    swrc_stream_if.sink                         i_sample,
    swrc_stream_if.source                       o_result,
    input  logic                                i_cfg_we,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import swrc_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [WLEN_W-1:0]        r_window_length, n_window_length;
    logic [THR_W-1:0]         r_range_threshold, n_range_threshold;
    logic [AW-1:0]            r_wr_slot, n_wr_slot;
    logic [CW-1:0]            r_seen, n_seen;
    logic [CW-1:0]            r_last_w, n_last_w;
    logic                     r_full, n_full;
    logic signed [DATA_W-1:0] r_hi, n_hi, r_lo, n_lo;
    logic [CW-1:0]            r_hi_age, n_hi_age, r_lo_age, n_lo_age;
    logic [AW-1:0]            r_rd_slot, n_rd_slot;
    logic [CW-1:0]            r_rd_left, n_rd_left;
    logic                     r_pend, n_pend;
    logic [CW-1:0]            r_scan_age, n_scan_age;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    logic                     acc;
    logic signed [DATA_W-1:0] v;
    logic [31:0]              wl32;
    logic [CW-1:0]            w_eff, seen_nx, n_cnt, hi_age_inc, lo_age_inc;
    logic                     hi_take, lo_take, need_scan, rd_issue, out_free;
    logic [AW-1:0]            prev_slot;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W:0]   range_w;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    assign acc      = i_sample.valid && i_sample.ready;
    assign v        = i_sample.payload.sample_value;
    assign rd_issue = (r_state == ST_SCAN) && (r_rd_left != '0);
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        wl32 = 32'(r_window_length);
        if (wl32 == 32'd0) begin
            w_eff = CW'(1);
        end else if (wl32 > 32'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(wl32);
        end
        seen_nx    = (r_seen < CW'(MAX_WINDOW)) ? r_seen + CW'(1) : r_seen;
        n_cnt      = (seen_nx < w_eff) ? seen_nx : w_eff;
        hi_take    = (v >= r_hi);
        lo_take    = (v <= r_lo);
        hi_age_inc = hi_take ? '0 : r_hi_age + CW'(1);
        lo_age_inc = lo_take ? '0 : r_lo_age + CW'(1);
        need_scan  = (r_seen == '0) || (w_eff != r_last_w)
                     || (hi_age_inc >= n_cnt) || (lo_age_inc >= n_cnt);
        prev_slot  = (r_wr_slot == '0) ? AW'(MAX_WINDOW - 1) : r_wr_slot - AW'(1);
        range_w    = {r_hi[DATA_W-1], r_hi} - {r_lo[DATA_W-1], r_lo};
    end

    swrc_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (acc),
        .i_waddr(r_wr_slot),
        .i_wdata(v),
        .i_re   (rd_issue),
        .i_raddr(r_rd_slot),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_state           = r_state;
        n_window_length   = r_window_length;
        n_range_threshold = r_range_threshold;
        n_wr_slot         = r_wr_slot;
        n_seen            = r_seen;
        n_last_w          = r_last_w;
        n_full            = r_full;
        n_hi              = r_hi;
        n_lo              = r_lo;
        n_hi_age          = r_hi_age;
        n_lo_age          = r_lo_age;
        n_rd_slot         = r_rd_slot;
        n_rd_left         = r_rd_left;
        n_pend            = 1'b0;
        n_scan_age        = r_scan_age;
        n_out_valid       = r_out_valid && !o_result.ready;
        n_out             = r_out;

        if (i_cfg_we) begin
            if (i_cfg_idx == REG_WINDOW_LENGTH) begin
                n_window_length = i_cfg_data[WLEN_W-1:0];
            end else if (i_cfg_idx == REG_RANGE_THRESHOLD) begin
                n_range_threshold = i_cfg_data[THR_W-1:0];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_wr_slot = (r_wr_slot == AW'(MAX_WINDOW - 1)) ? '0 : r_wr_slot + AW'(1);
                    n_seen    = seen_nx;
                    n_last_w  = w_eff;
                    n_full    = (seen_nx >= w_eff);
                    if (need_scan) begin
                        n_hi       = v;
                        n_lo       = v;
                        n_hi_age   = '0;
                        n_lo_age   = '0;
                        n_rd_slot  = prev_slot;
                        n_rd_left  = n_cnt - CW'(1);
                        n_scan_age = CW'(1);
                        n_state    = ST_SCAN;
                    end else begin
                        if (hi_take) begin
                            n_hi = v;
                        end
                        if (lo_take) begin
                            n_lo = v;
                        end
                        n_hi_age = hi_age_inc;
                        n_lo_age = lo_age_inc;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    n_rd_slot = (r_rd_slot == '0) ? AW'(MAX_WINDOW - 1) : r_rd_slot - AW'(1);
                    n_rd_left = r_rd_left - CW'(1);
                    n_pend    = 1'b1;
                end
                if (r_pend) begin
                    if ($signed(rd_data) > r_hi) begin
                        n_hi     = $signed(rd_data);
                        n_hi_age = r_scan_age;
                    end
                    if ($signed(rd_data) < r_lo) begin
                        n_lo     = $signed(rd_data);
                        n_lo_age = r_scan_age;
                    end
                    n_scan_age = r_scan_age + CW'(1);
                end
                if ((r_rd_left == '0) && !r_pend) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.window_max  = r_hi;
                    n_out.window_min  = r_lo;
                    n_out.window_full = r_full;
                    n_out.converged   = r_full
                                        && (range_w < $signed({2'b00, r_range_threshold}));
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_window_length   <= WLEN_RESET;
            r_range_threshold <= THR_RESET;
            r_wr_slot         <= '0;
            r_seen            <= '0;
            r_last_w          <= '0;
            r_full            <= 1'b0;
            r_rd_left         <= '0;
            r_pend            <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_window_length   <= n_window_length;
            r_range_threshold <= n_range_threshold;
            r_wr_slot         <= n_wr_slot;
            r_seen            <= n_seen;
            r_last_w          <= n_last_w;
            r_full            <= n_full;
            r_rd_left         <= n_rd_left;
            r_pend            <= n_pend;
            r_out_valid       <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_hi_age   <= n_hi_age;
        r_lo_age   <= n_lo_age;
        r_rd_slot  <= n_rd_slot;
        r_scan_age <= n_scan_age;
        r_out      <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_fast_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !need_scan) |=> (r_state == ST_EMIT))
        else $error("Transaction without rescan did not go straight to emit.");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_rd_left == '0) && !r_pend) |=> (r_state == ST_EMIT))
        else $error("Rescan did not finish after its last read.");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.window_max >= r_out.window_min))
        else $error("Window maximum below window minimum.");

    a_conv_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.converged) |-> r_out.window_full)
        else $error("Converged flag raised on a window that is not full.");
`endif

endmodule
